// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry format, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Port field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PAYLOAD_W  = 32;
  localparam int unsigned PRIO_IN_W  = 16;
  localparam int unsigned DOUT_W     = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STATUS_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One stored queue entry
  typedef struct packed {
    logic        [DATA_WIDTH-1:0] payload;
    logic signed [PRIO_WIDTH-1:0] prio;
  } entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     new_entry_i,
  input  logic                valid_i,
  input  logic                left_greater_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  spq_pkg::entry_t     right_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                greater_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // Slot is behind the new entry if empty or strictly larger (FIFO on ties)
  assign greater_o = !valid_i || ($signed(entry_q.prio) > $signed(new_entry_i.prio));

  // Next slot contents
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (greater_o && left_greater_i) begin
        entry_d = left_entry_i;
      end else if (greater_o) begin
        entry_d = new_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// The result strobe done_o rises the cycle after an accepted start.
// Throughput: one command per cycle, busy stays low; each command updates the
// whole row of compare-and-shift slots at once.
// Reset: rst_ni clears the entry count and the result strobe; slot contents
// are not cleared and only slots below the count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded minimum priority queue
// Row of slots kept sorted by ascending signed priority, front at slot 0,
// first in first out among equal priorities.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [spq_pkg::CMD_W-1:0]           cmd_i,
  input  logic [spq_pkg::PAYLOAD_W-1:0]       payload_i,
  input  logic signed [spq_pkg::PRIO_IN_W-1:0] priority_req_i,
  output logic                                done_o,
  output logic [spq_pkg::DOUT_W-1:0]          data_out_o,
  output logic [spq_pkg::COUNT_W-1:0]         count_o,
  output logic [spq_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned Depth = spq_pkg::DEPTH;
  localparam int unsigned CntW  = spq_pkg::CNT_W;

  logic                           accept;
  logic                           full, empty;
  spq_pkg::cell_ctrl_t            ctrl;
  spq_pkg::entry_t                new_entry;
  spq_pkg::entry_t                cell_entry [Depth];
  logic [Depth-1:0]               cell_greater;
  logic [Depth-1:0]               cell_valid;

  logic [CntW-1:0]                count_q, count_d;
  logic                           done_q;
  logic [spq_pkg::DOUT_W-1:0]     data_q, data_d;
  logic [spq_pkg::STATUS_W-1:0]   status_q, status_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(Depth));
  assign empty  = (count_q == '0);

  // Entry offered on an insert transfer
  assign new_entry.payload = spq_pkg::DATA_WIDTH'(payload_i);
  assign new_entry.prio    = spq_pkg::PRIO_WIDTH'(priority_req_i);

  // Command decode
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    data_d   = '0;
    status_d = spq_pkg::ST_OK;
    if (accept) begin
      unique case (cmd_i) inside
        spq_pkg::CMD_INSERT: begin
          if (full) begin
            status_d = spq_pkg::ST_FULL;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + 1'b1;
          end
        end
        spq_pkg::CMD_REMOVE, spq_pkg::CMD_PEEK: begin
          if (empty) begin
            status_d = spq_pkg::ST_EMPTY;
          end else begin
            data_d = spq_pkg::DOUT_W'(cell_entry[0].payload);
            if (cmd_i == spq_pkg::CMD_REMOVE) begin
              ctrl.remove = 1'b1;
              count_d     = count_q - 1'b1;
            end
          end
        end
        default: begin
          // unused code: ignored
        end
      endcase
    end
  end

  // Row of slots
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_greater;

    assign cell_valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign left_entry   = new_entry;
      assign left_greater = 1'b0;
    end else begin : g_mid
      assign left_entry   = cell_entry[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .new_entry_i    (new_entry),
      .valid_i        (cell_valid[i]),
      .left_greater_i (left_greater),
      .left_entry_i   (left_entry),
      .right_entry_i  (right_entry),
      .entry_o        (cell_entry[i]),
      .greater_o      (cell_greater[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign done_o     = done_q;
  assign data_out_o = data_q;
  assign status_o   = status_q;
  assign count_o    = spq_pkg::COUNT_W'(count_q);

endmodule

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches command transfers and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic [spq_pkg::DOUT_W-1:0]           data_out_o,
  input logic [spq_pkg::COUNT_W-1:0]          count_o,
  input logic [spq_pkg::STATUS_W-1:0]         status_o
);

  // Every accepted command gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("missing result after command transfer");

  // No result without a command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without command transfer");

  // Full is only reported with the queue at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_FULL) |->
      (count_o == spq_pkg::COUNT_W'(spq_pkg::DEPTH)))
    else $error("full status with queue not at capacity");

  // Empty is only reported on an empty queue, with zero data
  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_EMPTY) |-> (count_o == '0 && data_out_o == '0))
    else $error("empty status with entries held or nonzero data");

  // A count change between results is at most one entry
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      (count_o == $past(count_o) || count_o == $past(count_o) + 1'b1 ||
       count_o == $past(count_o) - 1'b1))
    else $error("count moved by more than one entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .data_out_o (data_out_o),
  .count_o    (count_o),
  .status_o   (status_o)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_queue
// Drives insert, remove, peek and unused commands with random idle gaps,
// predicts each result from a shadow copy of the sorted queue, and checks
// every result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  // Command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PLAN_ROWS    = 13;

  typedef struct packed {
    logic [DOUT_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  // One row of the directed plan; rows with 'typed' set carry a fixed answer
  typedef struct packed {
    logic [CMD_W-1:0]            cmd;
    logic [PAYLOAD_W-1:0]        payload;
    logic signed [PRIO_IN_W-1:0] prio;
    int                          reps;
    bit                          typed;
    outcome_t                    want;
  } plan_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [CMD_W-1:0]            cmd_i;
  logic [PAYLOAD_W-1:0]        payload_i;
  logic signed [PRIO_IN_W-1:0] priority_req_i;
  logic                        done_o;
  logic [DOUT_W-1:0]           data_out_o;
  logic [COUNT_W-1:0]          count_o;
  logic [STATUS_W-1:0]         status_o;

  // Shadow copy of the queue contents, front at index 0
  logic [DATA_WIDTH-1:0]        shadow_payload [DEPTH];
  logic signed [PRIO_WIDTH-1:0] shadow_prio    [DEPTH];
  int                           shadow_count;

  outcome_t pending_results [$];
  int       fail_count;
  int       cycle_count;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{CMD_PEEK,   32'h0,        16'sd0,      1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{CMD_REMOVE, 32'h0,        16'sd0,      1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{CMD_UNUSED, 32'hffffffff, -16'sd1,     1,  1'b1, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_INSERT, 32'hffffffff, 16'sh7fff,   1,  1'b1, '{32'h0, 5'd1,  ST_OK}},
    '{CMD_INSERT, 32'h0,        16'sh8000,   1,  1'b1, '{32'h0, 5'd2,  ST_OK}},
    // tie on the lowest priority: goes behind the earlier entry
    '{CMD_INSERT, 32'h12345678, 16'sh8000,   1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_UNUSED, 32'h0,        16'sd0,      1,  1'b1, '{32'h0, 5'd3,  ST_OK}},
    '{CMD_PEEK,   32'h0,        16'sd0,      1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_REMOVE, 32'h0,        16'sd0,      1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    // fill up with equal priorities, payload steps by one per entry
    '{CMD_INSERT, 32'ha5a50000, -16'sd1,     14, 1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_INSERT, 32'hdeadbeef, 16'sd0,      1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{CMD_PEEK,   32'h0,        16'sd0,      1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_REMOVE, 32'h0,        16'sd0,      1,  1'b0, '{32'h0, 5'd0,  ST_OK}}
  };

  sorted_priority_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .payload_i      (payload_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .data_out_o     (data_out_o),
    .count_o        (count_o),
    .status_o       (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one command to the shadow queue and return the result it gives
  function automatic outcome_t apply_command(logic [CMD_W-1:0] cmd,
                                             logic [PAYLOAD_W-1:0] pay,
                                             logic signed [PRIO_IN_W-1:0] prio);
    outcome_t res;
    int       pos;
    int       i;
    res.data   = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // first slot whose priority is strictly larger
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_payload[i] = shadow_payload[i-1];
            shadow_prio[i]    = shadow_prio[i-1];
          end
          shadow_payload[pos] = pay;
          shadow_prio[pos]    = prio;
          shadow_count++;
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = shadow_payload[0];
          if (cmd == CMD_REMOVE) begin
            for (i = 1; i < shadow_count; i++) begin
              shadow_payload[i-1] = shadow_payload[i];
              shadow_prio[i-1]    = shadow_prio[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // Present one command, hold it until the transfer, then idle for the requested gap
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic [PAYLOAD_W-1:0] pay,
                               input logic signed [PRIO_IN_W-1:0] prio,
                               input bit typed, input outcome_t want, input int gap);
    outcome_t predicted;
    start          <= 1'b1;
    cmd_i          <= cmd;
    payload_i      <= pay;
    priority_req_i <= prio;
    do @(posedge clk_i); while (busy);
    predicted = apply_command(cmd, pay, prio);
    pending_results.push_back(typed ? want : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker: every strobe must match the oldest prediction
  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data_out %h count %0d status %0d",
               data_out_o, count_o, status_o);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (data_out_o !== exp_res.data) begin
          $error("data_out: expected %h, got %h", exp_res.data, data_out_o);
          fail_count++;
        end
        if (count_o !== exp_res.count) begin
          $error("count: expected %0d, got %0d", exp_res.count, count_o);
          fail_count++;
        end
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int        sent;
    int        mode;
    int        run_len;
    int        pick;
    int        gap;
    bit        no_gaps;
    bit        tight_prio;
    logic [CMD_W-1:0]            cmd;
    logic signed [PRIO_IN_W-1:0] prio;
    outcome_t  none;

    none           = '0;
    fail_count     = 0;
    cycle_count    = 0;
    shadow_count   = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= CMD_PEEK;
    payload_i      <= '0;
    priority_req_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty queue, extremes, ties, full queue
    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        issue_command(directed_plan[r].cmd, directed_plan[r].payload + k,
                      directed_plan[r].prio, directed_plan[r].typed,
                      directed_plan[r].want, $urandom_range(0, 3));
      end
    end

    // Random part: runs biased toward filling, draining or a mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode       = $urandom_range(0, 2);
      run_len    = $urandom_range(10, 50);
      no_gaps    = ($urandom_range(0, 3) == 0);
      tight_prio = ($urandom_range(0, 1) == 1);
      for (int k = 0; k < run_len; k++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       cmd = (pick < 70) ? CMD_INSERT : (pick < 85) ? CMD_REMOVE :
                         (pick < 97) ? CMD_PEEK : CMD_UNUSED;
          1:       cmd = (pick < 20) ? CMD_INSERT : (pick < 85) ? CMD_REMOVE :
                         (pick < 97) ? CMD_PEEK : CMD_UNUSED;
          default: cmd = (pick < 45) ? CMD_INSERT : (pick < 85) ? CMD_REMOVE :
                         (pick < 97) ? CMD_PEEK : CMD_UNUSED;
        endcase
        // narrow keys force many ties, wide keys cover every bit
        if (tight_prio) prio = PRIO_IN_W'($signed($urandom_range(0, 6)) - 3);
        else            prio = PRIO_IN_W'($urandom_range(0, 65535));
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        issue_command(cmd, $urandom, prio, 1'b0, none, gap);
        sent++;
      end
    end
    start <= 1'b0;

    // Drain: wait for every outstanding result, then idle before the verdict
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
